@@ hw/rtl/usm_pkg.sv @@
`default_nettype none

package usm_pkg;

    // Line store geometry.
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int EW         = COL_W + 1;
    localparam int EH         = ROW_W + 1;
    localparam int LINES      = 4;
    localparam int MIN_SIZE   = 5;

    // Configuration register fields.
    localparam int CFG_W       = 13;
    localparam int GAIN_W      = 12;
    localparam int GAIN_RST    = 384;
    localparam int WIDTH_RST   = 1920;
    localparam int HEIGHT_RST  = 1080;

    typedef enum logic [1:0] {
        REG_GAIN   = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_HEIGHT = 2'd2
    } usm_reg_t;

    localparam logic ACT_DRAIN = 1'b1;

    // Gaussian kernel, sum 273.
    localparam int KSIZE = 5;
    localparam logic [5:0] KERN [KSIZE][KSIZE] = '{
        '{6'd1, 6'd4,  6'd7,  6'd4,  6'd1},
        '{6'd4, 6'd16, 6'd26, 6'd16, 6'd4},
        '{6'd7, 6'd26, 6'd41, 6'd26, 6'd7},
        '{6'd4, 6'd16, 6'd26, 6'd16, 6'd4},
        '{6'd1, 6'd4,  6'd7,  6'd4,  6'd1}
    };
    localparam int RS_W  = 15;
    localparam int SUM_W = 17;

    // floor(x / 273) == (x * 122911) >> 25 for every x up to 69615 (255 * 273), the largest kernel sum.
    localparam int               BLUR_SHIFT = 25;
    localparam logic [SUM_W-1:0] BLUR_RECIP = 17'd122911;
    localparam int               PROD_W     = 2 * SUM_W;

    // Output queue.
    localparam int FIFO_DEPTH = 16;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef struct packed {
        logic interior;
        logic last;
    } usm_tag_t;

    typedef struct packed {
        logic       last;
        logic [7:0] pixel;
    } usm_out_t;

    function automatic logic [EW-1:0] clamp_width(input logic [CFG_W-1:0] v);
        logic [EW-1:0] r;
        if (int'(v) < MIN_SIZE) begin
            r = EW'(MIN_SIZE);
        end else if (int'(v) > MAX_WIDTH) begin
            r = EW'(MAX_WIDTH);
        end else begin
            r = EW'(v);
        end
        return r;
    endfunction

    function automatic logic [EH-1:0] clamp_height(input logic [CFG_W-1:0] v);
        logic [EH-1:0] r;
        if (int'(v) < MIN_SIZE) begin
            r = EH'(MIN_SIZE);
        end else if (int'(v) > MAX_HEIGHT) begin
            r = EH'(MAX_HEIGHT);
        end else begin
            r = EH'(v);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/usm_ram.sv @@
`default_nettype none

module usm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // A read of the address being written returns the old contents.
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ hw/rtl/unsharp_mask_sharpen_5x5.sv @@
// Throughput: one request per cycle while s_tready is high, which it is until every
// output queue entry is spoken for; the four line-store RAMs take one read and one write
// per cycle, and a 16-entry output queue lets input continue while results wait.
// Reset (aresetn, synchronous, active low) clears the counters, pipeline and queue and
// restores the register defaults; the line stores are not cleared and need no clearing pass.
`default_nettype none

module unsharp_mask_sharpen_5x5 (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] pixel_in
    input  wire logic [0:0]  s_tuser,   // [0] action
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [7:0]  m_tdata,   // [7:0] pixel_out
    output logic             m_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [12:0] cfg_data
);

    localparam int COL_W = usm_pkg::COL_W;
    localparam int ROW_W = usm_pkg::ROW_W;
    localparam int EW    = usm_pkg::EW;
    localparam int EH    = usm_pkg::EH;
    localparam int KS    = usm_pkg::KSIZE;
    localparam int FAW   = usm_pkg::FIFO_AW;

    // Configuration.
    logic [usm_pkg::GAIN_W-1:0] gain_reg;
    logic [EW-1:0]              eff_w_reg;
    logic [EH-1:0]              eff_h_reg;

    // Raster position of the next input and the next output pixel.
    logic [COL_W-1:0] in_col_reg,  in_col_next;
    logic [EH-1:0]    in_row_reg,  in_row_next;
    logic [COL_W-1:0] out_col_reg, out_col_next;
    logic [ROW_W-1:0] out_row_reg, out_row_next;

    logic              accept;
    logic              drain_mode;
    logic              pix_rx;
    logic              out_due;
    logic              emit;
    logic              cfg_wr;
    logic              size_wr;
    usm_pkg::usm_tag_t tag;
    logic [EW-1:0]     in_col_inc;
    logic [EW-1:0]     out_col_inc;
    logic [EH-1:0]     out_row_inc;
    logic [COL_W-1:0]  ram_rd_addr;
    logic [7:0]        ram_rd_data [usm_pkg::LINES];

    // Pipeline registers.
    logic              s1_shift_reg, s1_emit_reg, s1_drain_reg;
    usm_pkg::usm_tag_t s1_tag_reg;
    logic [7:0]        s1_pix_reg;
    logic [1:0]        s1_rsel_reg, s1_dslot_reg;

    logic [7:0]        window_reg [KS][KS];
    logic              s2_emit_reg, s2_drain_reg;
    usm_pkg::usm_tag_t s2_tag_reg;
    logic [7:0]        s2_dval_reg;

    logic [usm_pkg::RS_W-1:0] row_sum [KS];
    logic [usm_pkg::RS_W-1:0] s3_rs_reg [KS];
    logic                     s3_emit_reg;
    usm_pkg::usm_tag_t        s3_tag_reg;
    logic [7:0]               s3_src_reg;

    logic [usm_pkg::SUM_W-1:0] sum_next;
    logic [usm_pkg::SUM_W-1:0] s4_sum_reg;
    logic                      s4_emit_reg;
    usm_pkg::usm_tag_t         s4_tag_reg;
    logic [7:0]                s4_src_reg;

    logic [usm_pkg::PROD_W-1:0] prod_next;
    logic [usm_pkg::PROD_W-1:0] s5_prod_reg;
    logic                       s5_emit_reg;
    usm_pkg::usm_tag_t          s5_tag_reg;
    logic [7:0]                 s5_src_reg;

    logic [7:0]        blur;
    logic              s6_neg_reg;
    logic [7:0]        s6_mag_reg;
    logic              s6_emit_reg;
    usm_pkg::usm_tag_t s6_tag_reg;
    logic [7:0]        s6_src_reg;

    logic [19:0]       gprod;
    logic [11:0]       s7_q_reg;
    logic              s7_neg_reg;
    logic              s7_emit_reg;
    usm_pkg::usm_tag_t s7_tag_reg;
    logic [7:0]        s7_src_reg;

    logic signed [13:0] res;
    logic [7:0]         res_clip;
    usm_pkg::usm_out_t  push_item;

    // Output queue with credit count of results in flight or stored.
    usm_pkg::usm_out_t fifo_mem [usm_pkg::FIFO_DEPTH];
    logic [FAW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [FAW:0]      fifo_cnt_reg, fifo_cnt_next;
    logic [FAW:0]      credit_reg, credit_next;
    logic              pop;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid & cfg_ready;
    assign size_wr   = cfg_wr & ((cfg_index == usm_pkg::REG_WIDTH) ||
                                 (cfg_index == usm_pkg::REG_HEIGHT));

    assign s_tready   = (credit_reg != (FAW + 1)'(usm_pkg::FIFO_DEPTH));
    assign accept     = s_tvalid & s_tready;
    assign drain_mode = (in_row_reg >= eff_h_reg);
    assign pix_rx     = accept & ~drain_mode & (s_tuser[0] != usm_pkg::ACT_DRAIN);
    // The output trails the input by two lines and two pixels.
    assign out_due    = (in_row_reg > EH'(2)) ||
                        ((in_row_reg == EH'(2)) && (in_col_reg >= COL_W'(2)));
    assign emit       = accept & (drain_mode | (pix_rx & out_due));

    assign in_col_inc  = EW'(in_col_reg) + EW'(1);
    assign out_col_inc = EW'(out_col_reg) + EW'(1);
    assign out_row_inc = EH'(out_row_reg) + EH'(1);

    always_comb begin
        tag.interior = (out_col_reg >= COL_W'(2)) && (out_row_reg >= ROW_W'(2)) &&
                       ((EW'(out_col_reg) + EW'(3)) <= eff_w_reg) &&
                       ((EH'(out_row_reg) + EH'(3)) <= eff_h_reg);
        tag.last     = (out_row_inc == eff_h_reg) && (out_col_inc == eff_w_reg);
    end

    always_comb begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (size_wr) begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end else begin
            if (pix_rx) begin
                if (in_col_inc == eff_w_reg) begin
                    in_col_next = '0;
                    in_row_next = in_row_reg + 1'b1;
                end else begin
                    in_col_next = in_col_reg + 1'b1;
                end
            end
            if (emit) begin
                if (tag.last) begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                end else if (out_col_inc == eff_w_reg) begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + 1'b1;
                end else begin
                    out_col_next = out_col_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg    <= usm_pkg::GAIN_W'(usm_pkg::GAIN_RST);
            eff_w_reg   <= usm_pkg::clamp_width(usm_pkg::CFG_W'(usm_pkg::WIDTH_RST));
            eff_h_reg   <= usm_pkg::clamp_height(usm_pkg::CFG_W'(usm_pkg::HEIGHT_RST));
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end else begin
            if (cfg_wr) begin
                case (cfg_index)
                    usm_pkg::REG_GAIN: begin
                        gain_reg <= cfg_data[usm_pkg::GAIN_W-1:0];
                    end
                    usm_pkg::REG_WIDTH: begin
                        eff_w_reg <= usm_pkg::clamp_width(cfg_data);
                    end
                    usm_pkg::REG_HEIGHT: begin
                        eff_h_reg <= usm_pkg::clamp_height(cfg_data);
                    end
                    default: begin
                    end
                endcase
            end
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    // One RAM per line slot; slot (row mod 4) holds that row. While draining, the
    // stores are read at the output column to fetch border pixels of the frame tail.
    assign ram_rd_addr = drain_mode ? out_col_reg : in_col_reg;

    for (genvar g = 0; g < usm_pkg::LINES; g++) begin : g_line
        usm_ram #(
            .WIDTH(8),
            .DEPTH(usm_pkg::MAX_WIDTH)
        ) u_line (
            .clk    (aclk),
            .wr_en  (pix_rx && (in_row_reg[1:0] == 2'(g))),
            .wr_addr(in_col_reg),
            .wr_data(s_tdata),
            .rd_addr(ram_rd_addr),
            .rd_data(ram_rd_data[g])
        );
    end

    // Stage 1: line-store data returns.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_shift_reg <= 1'b0;
            s1_emit_reg  <= 1'b0;
        end else begin
            s1_shift_reg <= pix_rx;
            s1_emit_reg  <= emit;
        end
        s1_drain_reg <= drain_mode;
        s1_tag_reg   <= tag;
        s1_pix_reg   <= s_tdata;
        s1_rsel_reg  <= in_row_reg[1:0];
        s1_dslot_reg <= out_row_reg[1:0];
    end

    // Stage 2: the window shifts left and takes the new column.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_emit_reg <= 1'b0;
        end else begin
            s2_emit_reg <= s1_emit_reg;
        end
        if (s1_shift_reg) begin
            for (int i = 0; i < KS; i++) begin
                for (int j = 0; j < KS - 1; j++) begin
                    window_reg[i][j] <= window_reg[i][j+1];
                end
            end
            for (int k = 0; k < usm_pkg::LINES; k++) begin
                window_reg[k][KS-1] <= ram_rd_data[2'(s1_rsel_reg + 2'(k))];
            end
            window_reg[KS-1][KS-1] <= s1_pix_reg;
        end
        s2_drain_reg <= s1_drain_reg;
        s2_tag_reg   <= s1_tag_reg;
        s2_dval_reg  <= ram_rd_data[s1_dslot_reg];
    end

    // Stage 3: weighted row sums.
    always_comb begin
        for (int i = 0; i < KS; i++) begin
            row_sum[i] = '0;
            for (int j = 0; j < KS; j++) begin
                row_sum[i] = row_sum[i] + usm_pkg::RS_W'(usm_pkg::KERN[i][j]) *
                             usm_pkg::RS_W'(window_reg[i][j]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_emit_reg <= 1'b0;
        end else begin
            s3_emit_reg <= s2_emit_reg;
        end
        s3_rs_reg  <= row_sum;
        s3_tag_reg <= s2_tag_reg;
        // Center pixel, or the stored pixel for tail items.
        s3_src_reg <= s2_drain_reg ? s2_dval_reg : window_reg[2][2];
    end

    // Stage 4: full kernel sum.
    always_comb begin
        sum_next = '0;
        for (int i = 0; i < KS; i++) begin
            sum_next = sum_next + usm_pkg::SUM_W'(s3_rs_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_emit_reg <= 1'b0;
        end else begin
            s4_emit_reg <= s3_emit_reg;
        end
        s4_sum_reg <= sum_next;
        s4_tag_reg <= s3_tag_reg;
        s4_src_reg <= s3_src_reg;
    end

    // Stage 5: divide by 273 through the reciprocal.
    assign prod_next = usm_pkg::PROD_W'(s4_sum_reg) * usm_pkg::PROD_W'(usm_pkg::BLUR_RECIP);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s5_emit_reg <= 1'b0;
        end else begin
            s5_emit_reg <= s4_emit_reg;
        end
        s5_prod_reg <= prod_next;
        s5_tag_reg  <= s4_tag_reg;
        s5_src_reg  <= s4_src_reg;
    end

    // Stage 6: detail magnitude and sign.
    assign blur = s5_prod_reg[usm_pkg::BLUR_SHIFT +: 8];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s6_emit_reg <= 1'b0;
        end else begin
            s6_emit_reg <= s5_emit_reg;
        end
        s6_neg_reg <= (s5_src_reg < blur);
        s6_mag_reg <= (s5_src_reg < blur) ? (blur - s5_src_reg) : (s5_src_reg - blur);
        s6_tag_reg <= s5_tag_reg;
        s6_src_reg <= s5_src_reg;
    end

    // Stage 7: scale the magnitude by the gain; dropping the fraction truncates toward zero.
    assign gprod = 20'(gain_reg) * 20'(s6_mag_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s7_emit_reg <= 1'b0;
        end else begin
            s7_emit_reg <= s6_emit_reg;
        end
        s7_q_reg   <= gprod[19:8];
        s7_neg_reg <= s6_neg_reg;
        s7_tag_reg <= s6_tag_reg;
        s7_src_reg <= s6_src_reg;
    end

    always_comb begin
        if (s7_neg_reg) begin
            res = $signed({6'b0, s7_src_reg}) - $signed({2'b0, s7_q_reg});
        end else begin
            res = $signed({6'b0, s7_src_reg}) + $signed({2'b0, s7_q_reg});
        end
        if (res < 0) begin
            res_clip = 8'd0;
        end else if (res > 14'sd255) begin
            res_clip = 8'd255;
        end else begin
            res_clip = res[7:0];
        end
        push_item.pixel = s7_tag_reg.interior ? res_clip : s7_src_reg;
        push_item.last  = s7_tag_reg.last;
    end

    // Output queue. Input is held off only when every queue entry is spoken for.
    assign pop      = m_tvalid & m_tready;
    assign m_tvalid = (fifo_cnt_reg != '0);
    assign m_tdata  = fifo_mem[rd_ptr_reg].pixel;
    assign m_tlast  = fifo_mem[rd_ptr_reg].last;

    assign fifo_cnt_next = fifo_cnt_reg + (FAW + 1)'(s7_emit_reg) - (FAW + 1)'(pop);
    assign credit_next   = credit_reg + (FAW + 1)'(emit) - (FAW + 1)'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
            credit_reg   <= '0;
        end else begin
            if (s7_emit_reg) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            fifo_cnt_reg <= fifo_cnt_next;
            credit_reg   <= credit_next;
        end
        if (s7_emit_reg) begin
            fifo_mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire
